// ===== rtl/sles_pkg.sv =====
// ----------------------------------------------------------------------------
// sles_pkg: shared types, codes and helpers for the string literal scanner
// Phase codes, status codes, character constants and the scanner state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sles_pkg;

	localparam int CpW = 21;
	localparam int ValW = 32;

	// scanner phase
	localparam logic [1:0] PH_BODY  = 2'd0;
	localparam logic [1:0] PH_ESC   = 2'd1;
	localparam logic [1:0] PH_HEX   = 2'd2;
	localparam logic [1:0] PH_AFTER = 2'd3;

	// result status
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_NEWLINE = 3'd1;
	localparam logic [2:0] ST_EOF     = 3'd2;
	localparam logic [2:0] ST_BAD_ESC = 3'd3;
	localparam logic [2:0] ST_BAD_HEX = 3'd4;

	// escape kinds
	localparam logic [1:0] EK_X  = 2'd0;
	localparam logic [1:0] EK_U4 = 2'd1;
	localparam logic [1:0] EK_U8 = 2'd2;

	localparam logic [CpW-1:0] CH_NUL       = 21'd0;
	localparam logic [CpW-1:0] CH_NL        = 21'd10;
	localparam logic [CpW-1:0] CH_QUOTE     = 21'd34;
	localparam logic [CpW-1:0] CH_BACKTICK  = 21'd96;
	localparam logic [CpW-1:0] CH_BSLASH    = 21'd92;
	localparam logic [CpW-1:0] CH_LOWER_X   = 21'd120;
	localparam logic [CpW-1:0] CH_LOWER_U   = 21'd117;
	localparam logic [CpW-1:0] CH_UPPER_U   = 21'd85;

	typedef struct packed {
		logic [1:0]      phase;
		logic [ValW-1:0] hex_acc;
		logic [3:0]      digits_left;
		logic [1:0]      escape_kind;
		logic            failed;
	} scan_state_t;

	typedef struct packed {
		logic            char_valid;
		logic [ValW-1:0] char_value;
		logic            char_consumed;
		logic            literal_end;
		logic [2:0]      status;
		logic            literal_ok;
	} scan_result_t;

	typedef struct packed {
		logic            hit;
		logic [ValW-1:0] value;
	} esc_dec_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] digit;
	} hex_dec_t;

	function automatic hex_dec_t hex_digit(input logic [CpW-1:0] c);
		hex_dec_t r;
		r.hit = 1'b1;
		r.digit = 4'd0;
		if (c >= 21'd48 && c <= 21'd57) begin
			r.digit = 4'(c - 21'd48);
		end else if (c >= 21'd97 && c <= 21'd102) begin
			r.digit = 4'(c - 21'd87);
		end else if (c >= 21'd65 && c <= 21'd70) begin
			r.digit = 4'(c - 21'd55);
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	function automatic logic is_gap(input logic [CpW-1:0] c);
		return c == 21'd32 || c == 21'd9 || c == 21'd11 || c == 21'd12 ||
			c == 21'd13 || c == CH_NL;
	endfunction

	function automatic esc_dec_t simple_escape(input logic [CpW-1:0] c);
		esc_dec_t r;
		r.hit = 1'b1;
		r.value = '0;
		unique case (c)
			21'd48:  r.value = 32'd0;
			21'd97:  r.value = 32'd7;
			21'd98:  r.value = 32'd8;
			21'd92:  r.value = 32'd92;
			21'd116: r.value = 32'd9;
			21'd110: r.value = 32'd10;
			21'd102: r.value = 32'd12;
			21'd114: r.value = 32'd13;
			21'd118: r.value = 32'd11;
			21'd39:  r.value = 32'd39;
			21'd34:  r.value = 32'd34;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sles_step.sv =====
// ----------------------------------------------------------------------------
// sles_step: one scanner step
// Decodes one code point against the current state, giving the next state
// and the result of the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sles_step (
	input  wire logic [sles_pkg::CpW-1:0] code_point,
	input  wire logic                     raw_literal,
	input  wire sles_pkg::scan_state_t    cur,
	output sles_pkg::scan_state_t         nxt,
	output sles_pkg::scan_result_t        res
);

	logic [sles_pkg::CpW-1:0] delim;
	sles_pkg::esc_dec_t       esc;
	sles_pkg::hex_dec_t       hex;
	logic [sles_pkg::ValW-1:0] acc_shift;
	logic [3:0]               digits_dec;

	assign delim = raw_literal ? sles_pkg::CH_BACKTICK : sles_pkg::CH_QUOTE;
	assign esc = sles_pkg::simple_escape(code_point);
	assign hex = sles_pkg::hex_digit(code_point);
	assign acc_shift = {cur.hex_acc[sles_pkg::ValW-5:0], hex.digit};
	assign digits_dec = cur.digits_left - 4'd1;

	always_comb begin
		nxt = cur;
		res.char_valid = 1'b0;
		res.char_value = '0;
		res.char_consumed = 1'b1;
		res.literal_end = 1'b0;
		res.status = sles_pkg::ST_NONE;
		res.literal_ok = 1'b0;

		unique case (cur.phase)
			sles_pkg::PH_BODY: begin
				if (!raw_literal && code_point == sles_pkg::CH_NL) begin
					res.char_consumed = 1'b0;
					res.literal_end = 1'b1;
					res.status = sles_pkg::ST_NEWLINE;
				end else if (code_point == sles_pkg::CH_NUL) begin
					res.char_consumed = 1'b0;
					res.literal_end = 1'b1;
					res.status = sles_pkg::ST_EOF;
				end else if (!raw_literal && code_point == sles_pkg::CH_BSLASH &&
						!cur.failed) begin
					nxt.phase = sles_pkg::PH_ESC;
				end else if (code_point == delim) begin
					nxt.phase = sles_pkg::PH_AFTER;
				end else begin
					res.char_valid = 1'b1;
					res.char_value = 32'(code_point);
				end
			end
			sles_pkg::PH_ESC: begin
				if (esc.hit) begin
					res.char_valid = 1'b1;
					res.char_value = esc.value;
					nxt.phase = sles_pkg::PH_BODY;
				end else if (code_point == sles_pkg::CH_LOWER_X) begin
					nxt.escape_kind = sles_pkg::EK_X;
					nxt.digits_left = 4'd2;
					nxt.hex_acc = '0;
					nxt.phase = sles_pkg::PH_HEX;
				end else if (code_point == sles_pkg::CH_LOWER_U) begin
					nxt.escape_kind = sles_pkg::EK_U4;
					nxt.digits_left = 4'd4;
					nxt.hex_acc = '0;
					nxt.phase = sles_pkg::PH_HEX;
				end else if (code_point == sles_pkg::CH_UPPER_U) begin
					nxt.escape_kind = sles_pkg::EK_U8;
					nxt.digits_left = 4'd8;
					nxt.hex_acc = '0;
					nxt.phase = sles_pkg::PH_HEX;
				end else begin
					res.char_valid = 1'b1;
					res.char_value = 32'(code_point);
					res.status = sles_pkg::ST_BAD_ESC;
					nxt.failed = 1'b1;
					nxt.phase = sles_pkg::PH_BODY;
				end
			end
			sles_pkg::PH_HEX: begin
				if (!hex.hit) begin
					// drop the non-hex character, emit the escape letter instead
					res.char_valid = 1'b1;
					unique case (cur.escape_kind)
						sles_pkg::EK_X:  res.char_value = 32'(sles_pkg::CH_LOWER_X);
						sles_pkg::EK_U4: res.char_value = 32'(sles_pkg::CH_LOWER_U);
						default:         res.char_value = 32'(sles_pkg::CH_UPPER_U);
					endcase
					res.status = sles_pkg::ST_BAD_HEX;
					nxt.failed = 1'b1;
					nxt.digits_left = 4'd0;
					nxt.hex_acc = '0;
					nxt.phase = sles_pkg::PH_BODY;
				end else begin
					nxt.hex_acc = acc_shift;
					nxt.digits_left = digits_dec;
					if (digits_dec == 4'd0) begin
						res.char_valid = 1'b1;
						res.char_value = acc_shift;
						nxt.hex_acc = '0;
						nxt.phase = sles_pkg::PH_BODY;
					end
				end
			end
			default: begin
				if (sles_pkg::is_gap(code_point)) begin
					nxt.phase = sles_pkg::PH_AFTER;
				end else if (code_point == delim) begin
					nxt.phase = sles_pkg::PH_BODY;
				end else begin
					res.char_consumed = 1'b0;
					res.literal_end = 1'b1;
					res.literal_ok = !cur.failed;
				end
			end
		endcase

		// every literal end starts the next literal from a clean state
		if (res.literal_end) begin
			nxt.phase = sles_pkg::PH_BODY;
			nxt.hex_acc = '0;
			nxt.digits_left = 4'd0;
			nxt.escape_kind = sles_pkg::EK_X;
			nxt.failed = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/string_literal_escape_scanner_top.sv =====
// ----------------------------------------------------------------------------
// string_literal_escape_scanner_top: string literal escape decoder
// Scans the code points of a string literal and emits decoded characters.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the code points that follow the opening delimiter on the s_ stream,
//   one per beat; s_tuser flags a raw (backtick) literal. Every input beat
//   gives exactly one result beat on the m_ stream: the decoded character
//   (when char_valid), whether the input was consumed, the status code and,
//   on the beat that closes the literal (m_tlast), literal_ok.
//   The beat is captured in an input register, decoded in one short step
//   against the scanner state, and held in the output register. Beats
//   go one per cycle while the receiver keeps up; the state update for one
//   code point is a single combinational step, so beats follow back to back.
//   When the receiver stalls, the output register holds its beat, the input
//   register still takes one more beat, and s_tready then drops until the
//   output drains.
//   Reset empties both registers and returns the scanner to the body phase
//   with no pending escape and no failure.
// ----------------------------------------------------------------------------
`default_nettype none

module string_literal_escape_scanner_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
	input  wire logic        s_tuser,   // [0] raw_literal
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // [31:0] char_value
	output      logic        m_tlast,   // literal_end
	output      logic [5:0]  m_tuser    // [0] char_valid, [1] char_consumed,
	                                    // [4:2] status, [5] literal_ok
);

	logic                      in_valid_s1;
	logic [sles_pkg::CpW-1:0]  code_point_s1;
	logic                      raw_literal_s1;
	logic                      advance;
	sles_pkg::scan_state_t     state_q;
	sles_pkg::scan_state_t     state_nxt;
	sles_pkg::scan_result_t    res;
	sles_pkg::scan_result_t    out_s2;

	// step the input register into the output register when it is free
	assign advance = in_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			code_point_s1 <= s_tdata[sles_pkg::CpW-1:0];
			raw_literal_s1 <= s_tuser;
		end
	end

	sles_step u_step (
		.code_point  (code_point_s1),
		.raw_literal (raw_literal_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= sles_pkg::PH_BODY;
			state_q.hex_acc <= '0;
			state_q.digits_left <= 4'd0;
			state_q.escape_kind <= sles_pkg::EK_X;
			state_q.failed <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= res;
		end
	end

	assign m_tdata = out_s2.char_value;
	assign m_tlast = out_s2.literal_end;
	assign m_tuser = {out_s2.literal_ok, out_s2.status, out_s2.char_consumed,
		out_s2.char_valid};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the string literal escape scanner
// Streams literal code points into the scanner, predicts each result beat
// from a local decoder with its own scanner state, and checks every field
// of the result stream in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module tb_top;
	import sles_pkg::*;

	localparam int DIRECTED_BEATS = 28;
	localparam int RANDOM_BEATS   = 1400;
	localparam int TAIL_BEATS     = 250;

	// escape letters that decode to a single character
	localparam logic [20:0] ESC_LETTERS [0:10] = '{
		21'd48, 21'd97, 21'd98, 21'd92, 21'd116, 21'd110,
		21'd102, 21'd114, 21'd118, 21'd39, 21'd34
	};
	// characters skipped between a closing and a reopening delimiter
	localparam logic [20:0] BLANKS [0:5] = '{
		21'd32, 21'd9, 21'd11, 21'd12, 21'd13, 21'd10
	};
	// characters that steer the scanner, used for noise beats
	localparam logic [20:0] STEERING [0:11] = '{
		21'd0, 21'd10, 21'd34, 21'd96, 21'd92, 21'd32,
		21'd120, 21'd117, 21'd85, 21'd48, 21'd65, 21'd103
	};

	class literal_scoreboard;
		scan_result_t expected_q[$];
		logic [1:0]   scan_phase;
		logic [31:0]  hex_acc;
		logic [3:0]   digits_to_go;
		logic [1:0]   esc_kind;
		logic         sticky_fail;
		int           errors;
		int           results_seen;

		function new();
			clear();
			errors = 0;
			results_seen = 0;
		endfunction

		function void clear();
			scan_phase = PH_BODY;
			hex_acc = '0;
			digits_to_go = '0;
			esc_kind = EK_X;
			sticky_fail = 1'b0;
		endfunction

		function bit is_blank(input logic [20:0] c);
			return c == 21'd32 || c == 21'd9 || c == 21'd11 || c == 21'd12 ||
				c == 21'd13 || c == CH_NL;
		endfunction

		function int hex_nibble(input logic [20:0] c);
			if (c >= 21'd48 && c <= 21'd57) return int'(c) - 48;
			if (c >= 21'd97 && c <= 21'd102) return int'(c) - 87;
			if (c >= 21'd65 && c <= 21'd70) return int'(c) - 55;
			return -1;
		endfunction

		function bit escape_value(input logic [20:0] c, output logic [31:0] v);
			bit hit;
			hit = 1'b1;
			v = '0;
			case (c)
				21'd48:  v = 32'd0;
				21'd97:  v = 32'd7;
				21'd98:  v = 32'd8;
				21'd92:  v = 32'd92;
				21'd116: v = 32'd9;
				21'd110: v = 32'd10;
				21'd102: v = 32'd12;
				21'd114: v = 32'd13;
				21'd118: v = 32'd11;
				21'd39:  v = 32'd39;
				21'd34:  v = 32'd34;
				default: hit = 1'b0;
			endcase
			return hit;
		endfunction

		// advance the scanner by one code point and return its result beat
		function scan_result_t decode_step(input logic [20:0] c, input logic raw);
			scan_result_t r;
			logic [20:0]  delim;
			logic [31:0]  esc;
			logic [20:0]  letter;
			int           nib;
			r = '0;
			r.char_consumed = 1'b1;
			delim = raw ? CH_BACKTICK : CH_QUOTE;
			case (scan_phase)
				PH_BODY: begin
					if (!raw && c == CH_NL) begin
						r.char_consumed = 1'b0;
						r.literal_end = 1'b1;
						r.status = ST_NEWLINE;
					end else if (c == CH_NUL) begin
						r.char_consumed = 1'b0;
						r.literal_end = 1'b1;
						r.status = ST_EOF;
					end else if (!raw && c == CH_BSLASH && !sticky_fail) begin
						scan_phase = PH_ESC;
					end else if (c == delim) begin
						scan_phase = PH_AFTER;
					end else begin
						r.char_valid = 1'b1;
						r.char_value = {11'd0, c};
					end
				end
				PH_ESC: begin
					if (escape_value(c, esc)) begin
						r.char_valid = 1'b1;
						r.char_value = esc;
						scan_phase = PH_BODY;
					end else if (c == CH_LOWER_X || c == CH_LOWER_U || c == CH_UPPER_U) begin
						esc_kind = (c == CH_LOWER_X) ? EK_X : (c == CH_LOWER_U) ? EK_U4 : EK_U8;
						digits_to_go = (c == CH_LOWER_X) ? 4'd2 : (c == CH_LOWER_U) ? 4'd4 : 4'd8;
						hex_acc = '0;
						scan_phase = PH_HEX;
					end else begin
						r.char_valid = 1'b1;
						r.char_value = {11'd0, c};
						r.status = ST_BAD_ESC;
						sticky_fail = 1'b1;
						scan_phase = PH_BODY;
					end
				end
				PH_HEX: begin
					nib = hex_nibble(c);
					if (nib < 0) begin
						// drop the offending character, emit the escape letter
						case (esc_kind)
							EK_X:    letter = CH_LOWER_X;
							EK_U4:   letter = CH_LOWER_U;
							default: letter = CH_UPPER_U;
						endcase
						r.char_valid = 1'b1;
						r.char_value = {11'd0, letter};
						r.status = ST_BAD_HEX;
						sticky_fail = 1'b1;
						digits_to_go = '0;
						hex_acc = '0;
						scan_phase = PH_BODY;
					end else begin
						hex_acc = {hex_acc[27:0], 4'(nib)};
						digits_to_go = digits_to_go - 4'd1;
						if (digits_to_go == 4'd0) begin
							r.char_valid = 1'b1;
							r.char_value = hex_acc;
							hex_acc = '0;
							scan_phase = PH_BODY;
						end
					end
				end
				default: begin
					if (!is_blank(c)) begin
						if (c == delim) begin
							scan_phase = PH_BODY;
						end else begin
							r.char_consumed = 1'b0;
							r.literal_end = 1'b1;
							r.literal_ok = !sticky_fail;
						end
					end
				end
			endcase
			if (r.literal_end) clear();
			return r;
		endfunction

		function void note_input(input logic [20:0] c, input logic raw);
			expected_q.push_back(decode_step(c, raw));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(input string msg);
			errors++;
			if (errors <= 50) $display("%0t MISMATCH %s", $time, msg);
		endfunction

		function void compare_field(input string name, input logic [31:0] got,
				input logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d: %s got %0h, want %0h",
					results_seen, name, got, want));
		endfunction

		function void check_result(input scan_result_t got);
			scan_result_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d: no result expected", results_seen));
				return;
			end
			want = expected_q.pop_front();
			compare_field("char_valid", 32'(got.char_valid), 32'(want.char_valid));
			compare_field("char_value", got.char_value, want.char_value);
			compare_field("char_consumed", 32'(got.char_consumed), 32'(want.char_consumed));
			compare_field("literal_end", 32'(got.literal_end), 32'(want.literal_end));
			compare_field("status", 32'(got.status), 32'(want.status));
			compare_field("literal_ok", 32'(got.literal_ok), 32'(want.literal_ok));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [5:0]  m_tuser;

	literal_scoreboard sb = new();
	int beats_sent = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	string_literal_escape_scanner_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin : result_mon
		scan_result_t got;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.char_valid    = m_tuser[0];
			got.char_value    = m_tdata;
			got.char_consumed = m_tuser[1];
			got.literal_end   = m_tlast;
			got.status        = m_tuser[4:2];
			got.literal_ok    = m_tuser[5];
			sb.check_result(got);
		end
	end

	// sink with random stall bursts
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_cp(input logic [20:0] cp, input logic raw);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, cp};
		s_tuser  <= raw;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		sb.note_input(cp, raw);
		beats_sent++;
	endtask

	// hold the source until every predicted beat has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [20:0] plain_char();
		logic [20:0] c;
		if ($urandom_range(0, 9) == 0) c = 21'($urandom_range(1, 21'h1FFFFF));
		else c = 21'($urandom_range(32, 126));
		if (c == CH_BSLASH || c == CH_QUOTE || c == CH_BACKTICK) c = 21'd97;
		return c;
	endfunction

	function automatic logic [20:0] hex_char();
		int n;
		n = $urandom_range(0, 21);
		if (n < 10) return 21'(48 + n);
		if (n < 16) return 21'(87 + n);
		return 21'(49 + n);
	endfunction

	function automatic logic [20:0] end_char(input logic raw);
		logic [20:0] c;
		case ($urandom_range(0, 4))
			0:       c = CH_NUL;
			1:       c = 21'd59;
			2:       c = 21'd41;
			3:       c = 21'($urandom_range(0, 21'h1FFFFF));
			default: c = raw ? CH_QUOTE : CH_BACKTICK;
		endcase
		if (sb.is_blank(c) || c == (raw ? CH_BACKTICK : CH_QUOTE)) c = 21'd59;
		return c;
	endfunction

	task automatic send_hex_escape(input logic raw, input bit broken);
		int          sel;
		int          digits;
		logic [20:0] letter;
		sel = $urandom_range(0, 2);
		letter = (sel == 0) ? CH_LOWER_X : (sel == 1) ? CH_LOWER_U : CH_UPPER_U;
		digits = (sel == 0) ? 2 : (sel == 1) ? 4 : 8;
		send_cp(CH_BSLASH, raw);
		send_cp(letter, raw);
		if (broken) begin
			repeat ($urandom_range(0, digits - 1)) send_cp(hex_char(), raw);
			case ($urandom_range(0, 4))
				0:       send_cp(21'd103, raw);
				1:       send_cp(CH_NUL, raw);
				2:       send_cp(CH_NL, raw);
				3:       send_cp(CH_QUOTE, raw);
				default: send_cp(21'($urandom_range(128, 21'h1FFFFF)), raw);
			endcase
		end else begin
			repeat (digits) send_cp(hex_char(), raw);
		end
	endtask

	// one literal: body pieces joined by delimiters, then a terminator
	task automatic send_literal(input logic raw);
		logic [20:0] delim;
		int          parts;
		int          p;
		int          k;
		int          n_tok;
		int          pick;
		delim = raw ? CH_BACKTICK : CH_QUOTE;
		parts = $urandom_range(1, 3);
		for (p = 0; p < parts; p++) begin
			n_tok = $urandom_range(0, 8);
			for (k = 0; k < n_tok; k++) begin
				pick = $urandom_range(0, 99);
				if (raw) begin
					if (pick < 80) send_cp(plain_char(), raw);
					else if (pick < 88) send_cp(CH_NL, raw);
					else if (pick < 97) send_cp(CH_BSLASH, raw);
					else begin
						send_cp(CH_NUL, raw);
						return;
					end
				end else if (pick < 45) begin
					send_cp(plain_char(), raw);
				end else if (pick < 65) begin
					send_cp(CH_BSLASH, raw);
					send_cp(ESC_LETTERS[$urandom_range(0, 10)], raw);
				end else if (pick < 85) begin
					send_hex_escape(raw, 1'b0);
				end else if (pick < 91) begin
					send_cp(CH_BSLASH, raw);
					case ($urandom_range(0, 3))
						0:       send_cp(21'd113, raw);
						1:       send_cp(CH_NUL, raw);
						2:       send_cp(CH_NL, raw);
						default: send_cp(21'($urandom_range(128, 21'h1FFFFF)), raw);
					endcase
				end else if (pick < 97) begin
					send_hex_escape(raw, 1'b1);
				end else begin
					// abandon the literal mid-body
					send_cp($urandom_range(0, 1) ? CH_NL : CH_NUL, raw);
					return;
				end
			end
			send_cp(delim, raw);
			repeat ($urandom_range(0, 2)) send_cp(BLANKS[$urandom_range(0, 5)], raw);
			if (p == parts - 1) send_cp(end_char(raw), raw);
			else send_cp(delim, raw);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 1))
				send_cp(STEERING[$urandom_range(0, 11)], 1'($urandom_range(0, 1)));
			else
				send_cp(21'($urandom_range(0, 21'h1FFFFF)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_directed();
		// widest code point, \0, \u00e9, bad hex digit, backslash after failure
		send_cp(21'h1FFFFF, 1'b0);
		send_cp(CH_BSLASH, 1'b0);
		send_cp(21'd48, 1'b0);
		send_cp(CH_BSLASH, 1'b0);
		send_cp(CH_LOWER_U, 1'b0);
		send_cp(21'd48, 1'b0);
		send_cp(21'd48, 1'b0);
		send_cp(21'd101, 1'b0);
		send_cp(21'd57, 1'b0);
		send_cp(CH_BSLASH, 1'b0);
		send_cp(CH_LOWER_X, 1'b0);
		send_cp(21'd103, 1'b0);
		send_cp(CH_BSLASH, 1'b0);
		// close, skip a line end, reopen, close, end on another character
		send_cp(CH_QUOTE, 1'b0);
		send_cp(CH_NL, 1'b0);
		send_cp(CH_QUOTE, 1'b0);
		send_cp(CH_QUOTE, 1'b0);
		send_cp(21'd66, 1'b0);
		// raw literal: newline and backslash are plain text
		send_cp(CH_NL, 1'b1);
		send_cp(CH_BSLASH, 1'b1);
		send_cp(CH_BACKTICK, 1'b1);
		send_cp(CH_NUL, 1'b1);
		// newline and end of input in the body
		send_cp(CH_NL, 1'b0);
		send_cp(CH_NUL, 1'b0);
		// escape phase consumes end of input as an unknown escape
		send_cp(CH_BSLASH, 1'b0);
		send_cp(CH_NUL, 1'b0);
		send_cp(CH_QUOTE, 1'b0);
		send_cp(21'd59, 1'b0);
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 5;
			2:       return 15;
			3:       return 30;
			default: return 50;
		endcase
	endfunction

	initial begin : stimulus
		int next_shuffle;
		bit drained_once;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		next_shuffle = 0;
		drained_once = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_for_results();

		while (beats_sent < DIRECTED_BEATS + RANDOM_BEATS) begin
			if (beats_sent >= DIRECTED_BEATS + RANDOM_BEATS - TAIL_BEATS) begin
				gap_pct = 0;
				stall_pct = 0;
			end else if (beats_sent >= next_shuffle) begin
				gap_pct = pick_pct();
				stall_pct = pick_pct();
				next_shuffle = beats_sent + 150;
			end
			if (!drained_once && beats_sent >= DIRECTED_BEATS + RANDOM_BEATS / 2) begin
				wait_for_results();
				drained_once = 1'b1;
			end
			if ($urandom_range(0, 99) < 85) send_literal($urandom_range(0, 3) == 0);
			else send_noise();
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
